@@ rtl/lkvt_pkg.sv @@
// package for the linear key/value table
// holds capacity, derived widths, stream word layouts, operation codes and sequencer states
// no dependencies
package lkvt_pkg;

    // table capacity and derived widths
    localparam int CAPACITY = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 64;
    localparam int VAL_W    = 64;
    localparam int KIND_W   = 3;
    localparam int ECNT_W   = 6;

    // stream word layouts
    localparam int IN_DATA_W  = 128;
    localparam int OUT_DATA_W = 72;
    localparam int OUT_USER_W = 2;

    // operation codes
    typedef enum logic [KIND_W-1:0] {
        OP_LOOKUP = 3'd0,
        OP_INSERT = 3'd1,
        OP_DELETE = 3'd2,
        OP_CLEAR  = 3'd3,
        OP_FIRST  = 3'd4,
        OP_NEXT   = 3'd5
    } t_op;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DEL_RD,
        S_DEL_WR,
        S_VAL_RD,
        S_VAL_CAP,
        S_RESP
    } t_state;

endpackage

@@ rtl/lkvt_ram.sv @@
// generic single write port, single read port ram with registered read
// no package dependencies
module lkvt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/linear_key_value_table_top.sv @@
// linear key/value table: unordered packed array with linear key scan
// the next word is taken only as the result of the last one appears in the output register,
// so one word is in work at a time; a full output register holds that result back
// a result word waits in an output register until taken
// reset (synchronous, active low) empties the table and zeroes the cursor
// depends on lkvt_pkg and lkvt_ram
module linear_key_value_table_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input stream
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [lkvt_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,  // key [63:0], data_in [127:64]
    input  logic [lkvt_pkg::KIND_W-1:0]      i_s_axis_tuser,  // kind [2:0]
    // result stream
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // data_out [63:0], entry_count [69:64], zero pad
    output logic [lkvt_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    output logic [lkvt_pkg::OUT_USER_W-1:0]  o_m_axis_tuser   // hit [0], dropped [1]
);
    import lkvt_pkg::*;

    // sequencer and item registers
    t_state               r_state, n_state;
    t_op                  r_op, n_op;
    logic [KEY_W-1:0]     r_key, n_key;
    logic [VAL_W-1:0]     r_din, n_din;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [CNT_W-1:0]     r_cursor, n_cursor;
    logic [CNT_W-1:0]     r_rd_idx, n_rd_idx;
    logic                 r_pend, n_pend;
    logic [IDX_W-1:0]     r_cmp_idx, n_cmp_idx;
    logic [IDX_W-1:0]     r_match, n_match;
    logic                 r_hit, n_hit;
    logic [VAL_W-1:0]     r_data, n_data;
    logic                 r_drop, n_drop;

    // output register
    logic                 r_o_valid, n_o_valid;
    logic                 r_o_hit, n_o_hit;
    logic [VAL_W-1:0]     r_o_data, n_o_data;
    logic [ECNT_W-1:0]    r_o_cnt, n_o_cnt;
    logic                 r_o_drop, n_o_drop;

    // memory ports
    logic                 key_we, val_we;
    logic [IDX_W-1:0]     waddr;
    logic [KEY_W-1:0]     key_wdata, key_rdata;
    logic [VAL_W-1:0]     val_wdata, val_rdata;

    // scratch
    logic                 in_acc;
    t_op                  in_op;
    logic [CNT_W-1:0]     cur_nx;
    logic                 key_eq;

    assign in_acc = i_s_axis_tvalid && (r_state == S_IDLE);
    assign in_op  = t_op'(i_s_axis_tuser);
    assign key_eq = r_pend && (key_rdata == r_key);

    // key and value stores
    lkvt_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (waddr),
        .i_wdata (key_wdata),
        .i_raddr (r_rd_idx[IDX_W-1:0]),
        .o_rdata (key_rdata)
    );

    lkvt_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (waddr),
        .i_wdata (val_wdata),
        .i_raddr (r_rd_idx[IDX_W-1:0]),
        .o_rdata (val_rdata)
    );

    // delete copies the last entry; otherwise the item's own key and value go in
    assign key_wdata = (r_state == S_DEL_WR) ? key_rdata : r_key;
    assign val_wdata = (r_state == S_DEL_WR) ? val_rdata : r_din;

    // next state and datapath control
    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_key     = r_key;
        n_din     = r_din;
        n_count   = r_count;
        n_cursor  = r_cursor;
        n_rd_idx  = r_rd_idx;
        n_pend    = r_pend;
        n_cmp_idx = r_cmp_idx;
        n_match   = r_match;
        n_hit     = r_hit;
        n_data    = r_data;
        n_drop    = r_drop;
        n_o_valid = r_o_valid && !i_m_axis_tready;
        n_o_hit   = r_o_hit;
        n_o_data  = r_o_data;
        n_o_cnt   = r_o_cnt;
        n_o_drop  = r_o_drop;
        key_we    = 1'b0;
        val_we    = 1'b0;
        waddr     = r_cmp_idx;
        cur_nx    = (r_cursor < CNT_W'(CAPACITY)) ? r_cursor + 1'b1 : r_cursor;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_op     = in_op;
                    n_key    = i_s_axis_tdata[KEY_W-1:0];
                    n_din    = i_s_axis_tdata[KEY_W +: VAL_W];
                    n_rd_idx = '0;
                    n_pend   = 1'b0;
                    n_hit    = 1'b0;
                    n_data   = '0;
                    n_drop   = 1'b0;
                    n_state  = S_RESP;
                    case (in_op)
                        OP_LOOKUP, OP_INSERT, OP_DELETE: begin
                            n_state = S_SCAN;
                        end
                        OP_CLEAR: begin
                            n_count  = '0;
                            n_cursor = '0;
                        end
                        OP_FIRST: begin
                            if (r_count != '0) begin
                                n_cursor = '0;
                                n_state  = S_VAL_RD;
                            end
                        end
                        OP_NEXT: begin
                            if (r_count != '0) begin
                                n_cursor = cur_nx;
                                if (cur_nx < r_count) begin
                                    n_rd_idx = cur_nx;
                                    n_state  = S_VAL_RD;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // one stored key compared per cycle, reads run one ahead
            S_SCAN: begin
                if (key_eq) begin
                    n_match = r_cmp_idx;
                    n_state = S_RESP;
                    case (r_op)
                        OP_LOOKUP: begin
                            n_hit  = 1'b1;
                            n_data = val_rdata;
                        end
                        OP_INSERT: begin
                            val_we = 1'b1;
                            waddr  = r_cmp_idx;
                            n_hit  = 1'b1;
                            n_data = r_din;
                        end
                        OP_DELETE: begin
                            n_hit    = 1'b1;
                            n_data   = val_rdata;
                            n_rd_idx = r_count - 1'b1;
                            n_state  = S_DEL_RD;
                        end
                        default: begin
                        end
                    endcase
                end else if (r_rd_idx < r_count) begin
                    n_pend    = 1'b1;
                    n_cmp_idx = r_rd_idx[IDX_W-1:0];
                    n_rd_idx  = r_rd_idx + 1'b1;
                end else begin
                    // key not present
                    n_state = S_RESP;
                    if (r_op == OP_INSERT) begin
                        if (r_count == CNT_W'(CAPACITY)) begin
                            n_drop = 1'b1;
                        end else begin
                            key_we  = 1'b1;
                            val_we  = 1'b1;
                            waddr   = r_count[IDX_W-1:0];
                            n_count = r_count + 1'b1;
                        end
                    end
                end
            end

            // read the last entry to fill the hole
            S_DEL_RD: begin
                n_state = S_DEL_WR;
            end

            S_DEL_WR: begin
                key_we  = 1'b1;
                val_we  = 1'b1;
                waddr   = r_match;
                n_count = r_count - 1'b1;
                n_state = S_RESP;
            end

            // iterate: read value at cursor
            S_VAL_RD: begin
                n_state = S_VAL_CAP;
            end

            S_VAL_CAP: begin
                n_hit   = 1'b1;
                n_data  = val_rdata;
                n_state = S_RESP;
            end

            // hand the result word to the output register when it is free
            S_RESP: begin
                if (!r_o_valid || i_m_axis_tready) begin
                    n_o_valid = 1'b1;
                    n_o_hit   = r_hit;
                    n_o_data  = r_data;
                    n_o_cnt   = ECNT_W'(r_count);
                    n_o_drop  = r_drop;
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_cursor  <= '0;
            r_o_valid <= 1'b0;
            r_pend    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_cursor  <= n_cursor;
            r_o_valid <= n_o_valid;
            r_pend    <= n_pend;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_key     <= n_key;
        r_din     <= n_din;
        r_rd_idx  <= n_rd_idx;
        r_cmp_idx <= n_cmp_idx;
        r_match   <= n_match;
        r_hit     <= n_hit;
        r_data    <= n_data;
        r_drop    <= n_drop;
        r_o_hit   <= n_o_hit;
        r_o_data  <= n_o_data;
        r_o_cnt   <= n_o_cnt;
        r_o_drop  <= n_o_drop;
    end

    // ports
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = {2'b00, r_o_cnt, r_o_data};
    assign o_m_axis_tuser  = {r_o_drop, r_o_hit};

endmodule
